// ===== rtl/rmst_pkg.sv =====
package rmst_pkg;

   // Fixed field widths of the request and response items.
   localparam int POS_W  = 10;
   localparam int DATA_W = 32;

   // Request type codes.
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Value held by every node after reset, and the empty-range answer.
   localparam logic signed [DATA_W-1:0] NODE_INIT = -32'sd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_U_LEAF,
      ST_U_PATH,
      ST_Q_LEFT,
      ST_Q_RIGHT,
      ST_DONE
   } rmst_state_type;

endpackage

// ===== rtl/rmst_if.sv =====
interface rmst_req_if;
   import rmst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [POS_W-1:0]         position;
   logic [POS_W-1:0]         range_end;
   logic signed [DATA_W-1:0] new_value;

   modport source (output valid, req_type, position, range_end, new_value, input ready);
   modport sink   (input valid, req_type, position, range_end, new_value, output ready);
endinterface

interface rmst_rsp_if;
   import rmst_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;

   modport source (output valid, result_value, input ready);
   modport sink   (input valid, result_value, output ready);
endinterface

// ===== rtl/rmst_ram.sv =====
module rmst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/range_max_segment_tree.sv =====
// Range-maximum segment tree over LEAVES signed 32-bit leaves, all starting at -1.
// Requests arrive on the req channel (valid/ready). An item with req_type update
// raises leaf "position" to the maximum of its old value and new_value, refreshes
// every ancestor up to the root, and answers with the new leaf value (or -1 when
// the position lies beyond the leaves). A query item answers with the maximum over
// leaves position..range_end inclusive, the end clamped to the last leaf, or -1
// when the range is empty. Every item gives exactly one response on the rsp channel.
// The node maxima live in a single memory of 2*LEAVES words with registered reads.
// An update does one read-modify-write per level, from the leaf up to the root; a
// query walk visits up to log2(LEAVES)+1 levels, and each needs up to two memory
// reads through the one read port. One item is worked at a time.
// After reset the block sweeps the memory to -1, one word a cycle; req.ready stays
// low until the sweep ends. A finished response sits in an output register, so a
// new item can be accepted while it waits; if the receiver still holds off when the
// next response is ready, the block waits.
module range_max_segment_tree #(
   parameter int LEAVES = 1024
) (
   input  logic            clock,
   input  logic            reset,
   rmst_req_if.sink        req,
   rmst_rsp_if.source      rsp
);
   import rmst_pkg::*;

   // Node index width, and a wider width for range bounds, which reach 2*LEAVES.
   localparam int AW = $clog2(LEAVES) + 1;
   localparam int XW = ((AW > POS_W) ? AW : POS_W) + 1;
   localparam int DEPTH = 2 * LEAVES;

   rmst_state_type           state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [XW-1:0]            lo_ff, lo_in;
   logic [XW-1:0]            hi_ff, hi_in;
   logic signed [DATA_W-1:0] cur_ff, cur_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic                     pend_ff, pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic [AW-1:0]            rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rd_sval;

   logic [XW-1:0]            pos_x, end_x, last_x, hi_clamp, par_idx;
   logic signed [DATA_W-1:0] acc;
   logic signed [DATA_W-1:0] leaf_val, par_val;
   logic                     out_free;

   rmst_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_sval  = $signed(rd_data);
   assign pos_x    = XW'(req.position);
   assign end_x    = XW'(req.range_end);
   assign last_x   = XW'(LEAVES - 1);
   assign hi_clamp = (end_x > last_x) ? last_x : end_x;
   assign par_idx  = lo_ff >> 1;

   // Fold the word read in the previous cycle into the running query maximum.
   assign acc      = (pend_ff && (rd_sval > res_ff)) ? rd_sval : res_ff;
   assign leaf_val = (rd_sval > cur_ff) ? rd_sval : cur_ff;
   assign par_val  = (rd_sval > cur_ff) ? rd_sval : cur_ff;
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      cur_ff      <= cur_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = lo_ff[AW-1:0];
      wr_data      = NODE_INIT;
      rd_addr      = lo_ff[AW-1:0];
      req.ready    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = NODE_INIT;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.req_type == REQ_UPDATE) begin
                  if (pos_x > last_x) begin
                     res_in   = NODE_INIT;
                     state_in = ST_DONE;
                  end else begin
                     // Read the leaf; the merge happens when the word returns.
                     lo_in    = pos_x + XW'(LEAVES);
                     rd_addr  = lo_in[AW-1:0];
                     cur_in   = req.new_value;
                     state_in = ST_U_LEAF;
                  end
               end else begin
                  res_in = NODE_INIT;
                  if (pos_x > hi_clamp) begin
                     state_in = ST_DONE;
                  end else begin
                     lo_in    = pos_x + XW'(LEAVES);
                     hi_in    = hi_clamp + XW'(LEAVES) + XW'(1);
                     state_in = ST_Q_LEFT;
                  end
               end
            end
         end

         ST_U_LEAF: begin
            // Write the raised leaf and fetch its sibling in the same cycle.
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_data  = leaf_val;
            rd_addr  = {lo_ff[AW-1:1], ~lo_ff[0]};
            cur_in   = leaf_val;
            res_in   = leaf_val;
            state_in = ST_U_PATH;
         end

         ST_U_PATH: begin
            // Parent is the max of the node just written and its sibling.
            wr_en   = 1'b1;
            wr_addr = par_idx[AW-1:0];
            wr_data = par_val;
            cur_in  = par_val;
            lo_in   = par_idx;
            rd_addr = {par_idx[AW-1:1], ~par_idx[0]};
            if (par_idx == XW'(1)) begin
               state_in = ST_DONE;
            end
         end

         ST_Q_LEFT: begin
            res_in = acc;
            if (lo_ff >= hi_ff) begin
               state_in = ST_DONE;
            end else begin
               if (lo_ff[0]) begin
                  rd_addr = lo_ff[AW-1:0];
                  pend_in = 1'b1;
                  lo_in   = lo_ff + XW'(1);
               end
               state_in = ST_Q_RIGHT;
            end
         end

         ST_Q_RIGHT: begin
            res_in = acc;
            if (hi_ff[0]) begin
               rd_addr = {hi_ff[AW-1:1], 1'b0};
               pend_in = 1'b1;
            end
            // An odd right bound steps down by one first; the shift covers both.
            lo_in    = lo_ff >> 1;
            hi_in    = hi_ff >> 1;
            state_in = ST_Q_LEFT;
         end

         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_data_ff;
endmodule
